@@ sv/htim_pkg.sv @@
// ----------------------------------------------------------------------------
// Handheld console timer package
// Shared item codes, control masks, the command structure passed from the
// timer's controller to its datapath, and the controller status structure.
// ----------------------------------------------------------------------------
`default_nettype none

package htim_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_CTRL  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Control register layout: enable bit and tap select.
  localparam logic [2:0] CTL_EN_MASK  = 3'h4;
  localparam logic [2:0] CTL_SEL_MASK = 3'h3;
  localparam logic [7:0] CTL_MASK     = 8'h07;

  // Tap select codes.
  localparam logic [1:0] TAP_BIT9 = 2'd0;
  localparam logic [1:0] TAP_BIT3 = 2'd1;
  localparam logic [1:0] TAP_BIT5 = 2'd2;
  localparam logic [1:0] TAP_BIT7 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // a new word has been accepted; clears the interrupt flag
    logic do_tick;   // advance the divider by one clock
    logic do_reset;  // clear the divider
    logic do_ctrl;   // write the control bits
    logic load_out;  // capture the result word into the output register
  } htim_cmd_t;

  // Controller status, observed at the top level.
  typedef struct packed {
    logic tick_active;
    logic cnt_zero;
    logic load_out;
  } htim_stat_t;

  // Timer input signal: the selected divider bit gated by the enable bit.
  function automatic logic sample_tap(input logic [15:0] div, input logic [2:0] ctl);
    logic bit_v;
    logic [1:0] sel;
    sel = 2'(ctl & CTL_SEL_MASK);
    case (sel)
      TAP_BIT9: bit_v = div[9];
      TAP_BIT3: bit_v = div[3];
      TAP_BIT5: bit_v = div[5];
      TAP_BIT7: bit_v = div[7];
      default:  bit_v = 1'b0;
    endcase
    return ((ctl & CTL_EN_MASK) != 3'h0) && bit_v;
  endfunction

endpackage

`default_nettype wire

@@ sv/handheld_console_timer.sv @@
// ----------------------------------------------------------------------------
// Handheld console timer
// Divider and counter timer with tap select, stepped by input words.
// ----------------------------------------------------------------------------
// Each input word is a tick word, a divider reset or a control write, chosen
// by in_tuser. Every word produces exactly one output word carrying the
// upper divider byte, the counter, the control bits and an interrupt flag.
// A tick word advances the divider one clock per cycle in the datapath, once per
// tick of tick_cycles (saturated to MAX_TICKS); a reset, control write, unused
// kind or zero-tick word goes straight to the done state. The result is
// captured there, and out_tvalid rises in the cycle after that capture.
// in_tready is high only while no word is in progress; the next word may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits inside the block until
// the output register is free, and no new word is taken meanwhile.
// The reload register is written with cfg_we and cfg_wdata by the user while idle
// (unenforced). Reset clears divider, counter, control bits, reload, all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_console_timer #(
  parameter int MAX_TICKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [6:0] tick_cycles, [14:7] control_value
  input  wire logic [1:0]  in_tuser,  // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // [7:0] divider_high, [15:8] counter_value,
                                      // [18:16] control_now, [19] timer_irq
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  import htim_pkg::*;

  htim_cmd_t  cmd;
  htim_stat_t stat;

  // Controller.
  htim_ctrl #(
    .MAX_TICKS (MAX_TICKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .in_ticks   (in_tdata[6:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Datapath.
  htim_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ctrl_byte (in_tdata[14:7]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_tdata)
  );

  // A tick sequence never runs with an exhausted count.
  a_tick_count : assert property (@(posedge clk) disable iff (!rst_n)
    stat.tick_active |-> !stat.cnt_zero)
    else $error("tick sequence running with zero count");

  // Once a word is taken, no further word is accepted in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is in progress");

  // A captured result is presented on the output in the following cycle.
  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    stat.load_out |=> (out_tvalid && in_tready))
    else $error("captured result not presented");

endmodule

`default_nettype wire

@@ sv/htim_ctrl.sv @@
// ----------------------------------------------------------------------------
// Handheld console timer controller
// Accepts input words, sequences the clock ticks of a tick word one per cycle
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module htim_ctrl #(
  parameter int MAX_TICKS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [1:0]           in_mode,
  input  wire logic [6:0]           in_ticks,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output htim_pkg::htim_cmd_t       cmd,
  output htim_pkg::htim_stat_t      stat
);
  import htim_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [7:0] MaxTicksW = 8'(MAX_TICKS);

  logic [1:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic [7:0] ticks_w;
  logic [7:0] eff_w;

  // Saturate the requested tick count.
  assign ticks_w = {1'b0, in_ticks};
  assign eff_w   = (ticks_w > MaxTicksW) ? MaxTicksW : ticks_w;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          if ((in_mode == MODE_TICK) && (eff_w != 8'd0)) begin
            cnt_nxt   = eff_w[6:0];
            state_nxt = S_TICK;
          end else begin
            cmd.do_reset = (in_mode == MODE_RESET);
            cmd.do_ctrl  = (in_mode == MODE_CTRL);
            state_nxt    = S_DONE;
          end
        end
      end
      S_TICK: begin
        cmd.do_tick = 1'b1;
        cnt_nxt     = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output word stays valid until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.tick_active = (state_r == S_TICK);
  assign stat.cnt_zero    = (cnt_r == 7'd0);
  assign stat.load_out    = cmd.load_out;

endmodule

`default_nettype wire

@@ sv/htim_dp.sv @@
// ----------------------------------------------------------------------------
// Handheld console timer datapath
// Holds the divider, counter, control and reload registers, detects falling
// edges of the timer input and captures the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module htim_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire htim_pkg::htim_cmd_t  cmd,
  input  wire logic [7:0]           ctrl_byte,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  output logic [23:0]               out_word
);
  import htim_pkg::*;

  logic [15:0] div_r, div_nxt;
  logic [7:0]  counter_r, counter_nxt;
  logic [2:0]  ctl_r, ctl_nxt;
  logic [7:0]  reload_r;
  logic        irq_r, irq_nxt;
  logic [23:0] out_r;
  logic        before_s, after_s, fall;
  logic [7:0]  inc;
  logic        ovf;

  // New divider and control values for this cycle.
  always_comb begin
    ctl_nxt = cmd.do_ctrl ? 3'(ctrl_byte & CTL_MASK) : ctl_r;
    if (cmd.do_reset) begin
      div_nxt = '0;
    end else if (cmd.do_tick) begin
      div_nxt = div_r + 16'd1;
    end else begin
      div_nxt = div_r;
    end
  end

  // Falling edge of the timer input steps the counter; overflow reloads it.
  always_comb begin
    before_s    = sample_tap(div_r, ctl_r);
    after_s     = sample_tap(div_nxt, ctl_nxt);
    fall        = before_s && !after_s;
    inc         = counter_r + 8'd1;
    ovf         = fall && (inc == 8'd0);
    counter_nxt = counter_r;
    if (fall) begin
      counter_nxt = ovf ? reload_r : inc;
    end
    irq_nxt = (cmd.start ? 1'b0 : irq_r) | ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r     <= '0;
      counter_r <= '0;
      ctl_r     <= '0;
      reload_r  <= '0;
      irq_r     <= 1'b0;
    end else begin
      div_r     <= div_nxt;
      counter_r <= counter_nxt;
      ctl_r     <= ctl_nxt;
      irq_r     <= irq_nxt;
      if (cfg_we) begin
        reload_r <= cfg_wdata;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {4'd0, irq_r, ctl_r, counter_r, div_r[15:8]};
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire
